### rtl/swq_pkg.sv
// Shared types and constants for the sorted priority wait queue.
// Used by swq_cell, sorted_priority_wait_queue and the bench; no other dependencies.
package swq_pkg;

	localparam int ID_W         = 16;
	localparam int LVL_W        = 3;
	localparam int OCC_W        = 5;
	localparam int DEPTH_DEF    = 16;
	localparam int LEVELS_DEF   = 8;
	localparam int IN_DATA_W    = 24;
	localparam int IN_USER_W    = 2;
	localparam int OUT_DATA_W   = 32;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_DEQUEUE = 2'd1,
		REQ_QUERY   = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Contents of one cell as seen by its neighbors
	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
	} entry_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic             enq;
		logic             deq;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
	} cmd_t;

endpackage

### rtl/swq_cell.sv
// One slot of the sorted queue: holds an entry and shifts to or from its neighbors.
// Depends on swq_pkg for entry_t and cmd_t.
module swq_cell import swq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  logic   left_ins,
	input  entry_t left_entry,
	input  entry_t right_entry,
	output entry_t entry,
	output logic   ins,
	output logic   match
);

	logic             valid_q;
	logic [ID_W-1:0]  id_q;
	logic [LVL_W-1:0] lvl_q;

	// The new item belongs here or further toward the head
	assign ins   = !valid_q || (cmd.lvl <= lvl_q);
	assign match = valid_q && (id_q == cmd.id);
	assign entry = '{valid: valid_q, id: id_q, lvl: lvl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.enq && ins) begin
			valid_q <= left_ins ? left_entry.valid : 1'b1;
		end else if (cmd.deq) begin
			valid_q <= right_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq && ins) begin
			// shift back behind the neighbor, or take the new item at the boundary
			if (left_ins) begin
				id_q  <= left_entry.id;
				lvl_q <= left_entry.lvl;
			end else begin
				id_q  <= cmd.id;
				lvl_q <= cmd.lvl;
			end
		end else if (cmd.deq) begin
			id_q  <= right_entry.id;
			lvl_q <= right_entry.lvl;
		end
	end

endmodule

### rtl/sorted_priority_wait_queue.sv
// Sorted priority wait queue: a chain of QUEUE_DEPTH cells kept in level order.
// Each accepted request's result is loaded into the output register in the next cycle.
// One request per cycle unless output stalls; every cell compares and shifts in parallel.
// Reset: arst_n clears all cell valid bits, the count and the output valid.
// Depends on swq_pkg and swq_cell.
module sorted_priority_wait_queue import swq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF,
	parameter int LEVEL_COUNT = LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// requester_id[15:0], priority_level[18:16], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// req_type[1:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[1:0], head_id[17:2], head_level[20:18], present[21], occupancy[26:22], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic             accept;
	req_t             req;
	logic [ID_W-1:0]  in_id;
	logic [LVL_W-1:0] in_lvl_raw;
	logic [LVL_W-1:0] in_lvl;
	logic             full;
	logic             empty;
	cmd_t             cmd;

	entry_t           entries [QUEUE_DEPTH];
	logic             ins_v   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] match_v;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [ID_W-1:0]  head_id_q;
	logic [LVL_W-1:0] head_lvl_q;
	logic             present_q;
	logic [OCC_W-1:0] occ_q;

	status_t          status_d;
	logic [CNT_W-1:0] count_d;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = req_t'(s_axis_tuser);
	assign in_id         = s_axis_tdata[ID_W-1:0];
	assign in_lvl_raw    = s_axis_tdata[ID_W+LVL_W-1:ID_W];

	// Saturate levels beyond the configured range
	assign in_lvl = (9'(in_lvl_raw) >= 9'(LEVEL_COUNT)) ? LVL_W'(LEVEL_COUNT - 1) : in_lvl_raw;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign cmd = '{
		enq: accept && (req == REQ_ENQUEUE) && !full,
		deq: accept && (req == REQ_DEQUEUE) && !empty,
		id:  in_id,
		lvl: in_lvl
	};

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_i;

		if (k == 0) begin : g_head
			assign left_e = '0;
			assign left_i = 1'b0;
		end else begin : g_mid
			assign left_e = entries[k-1];
			assign left_i = ins_v[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = entries[k+1];
		end

		swq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_ins    (left_i),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (entries[k]),
			.ins         (ins_v[k]),
			.match       (match_v[k])
		);
	end

	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		unique case (req)
			REQ_ENQUEUE: begin
				if (full) status_d = ST_FULL;
				else      count_d  = count_q + CNT_W'(1);
			end
			REQ_DEQUEUE: begin
				if (empty) status_d = ST_EMPTY;
				else       count_d  = count_q - CNT_W'(1);
			end
			REQ_QUERY, REQ_NONE: begin
				status_d = ST_DONE;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			present_q  <= (req == REQ_QUERY) && (|match_v);
			occ_q      <= OCC_W'(count_d);
			// head of the chain leaves on a dequeue
			if (cmd.deq) begin
				head_id_q  <= entries[0].id;
				head_lvl_q <= entries[0].lvl;
			end else begin
				head_id_q  <= '0;
				head_lvl_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, occ_q, present_q, head_lvl_q, head_id_q, status_q};

endmodule

### bench/swq_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted priority wait queue: watches both streams, predicts each result.
// Keeps its own ordered copy of the queue. Depends on swq_pkg only.
module swq_checker import swq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEPTH_DEF,
	parameter int LEVEL_COUNT = LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// requester_id[15:0], priority_level[18:16], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// req_type[1:0]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[1:0], head_id[17:2], head_level[20:18], present[21], occupancy[26:22], zero fill
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    errors,
	output int                    answers_due,
	output int                    answered,
	output int                    dropped,
	output int                    empty_reads,
	output int                    query_hits
);

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  head_id;
		logic [LVL_W-1:0] head_level;
		logic             present;
		logic [OCC_W-1:0] occupancy;
	} answer_t;

	answer_t          answers[$];
	answer_t          want;
	answer_t          got;
	logic [ID_W-1:0]  held_ids[QUEUE_DEPTH];
	logic [LVL_W-1:0] held_levels[QUEUE_DEPTH];
	int               held;
	int               fail_count;
	int               answer_count;
	int               drop_count;
	int               empty_count;
	int               hit_count;

	// Apply one request to the local copy of the queue and return its answer
	function automatic answer_t serve_request(req_t req, logic [ID_W-1:0] id,
			logic [LVL_W-1:0] level);
		answer_t ans;
		int      pos;
		ans = '0;
		ans.status = ST_DONE;
		if (int'(level) >= LEVEL_COUNT)
			level = LVL_W'(LEVEL_COUNT - 1);
		case (req)
			REQ_ENQUEUE: begin
				if (held >= QUEUE_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					// insert ahead of the first entry with an equal or larger level
					pos = 0;
					while (pos < held && level > held_levels[pos])
						pos++;
					for (int k = held; k > pos; k--) begin
						held_ids[k]    = held_ids[k-1];
						held_levels[k] = held_levels[k-1];
					end
					held_ids[pos]    = id;
					held_levels[pos] = level;
					held++;
				end
			end
			REQ_DEQUEUE: begin
				if (held == 0) begin
					ans.status = ST_EMPTY;
				end else begin
					ans.head_id    = held_ids[0];
					ans.head_level = held_levels[0];
					for (int k = 1; k < held; k++) begin
						held_ids[k-1]    = held_ids[k];
						held_levels[k-1] = held_levels[k];
					end
					held--;
				end
			end
			REQ_QUERY: begin
				for (int k = 0; k < held; k++)
					if (held_ids[k] == id)
						ans.present = 1'b1;
			end
			default: ;
		endcase
		ans.occupancy = OCC_W'(held);
		return ans;
	endfunction

	task automatic check_field(string name, int expected, int actual);
		if (expected != actual) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d",
				$time, name, expected, actual);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answers.delete();
			held         = 0;
			fail_count   = 0;
			answer_count = 0;
			drop_count   = 0;
			empty_count  = 0;
			hit_count    = 0;
		end else begin
			// compare first: a result leaving now always belongs to an older item
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with nothing expected, got tdata 0x%08h",
						$time, m_axis_tdata);
				end else begin
					want = answers[0];
					answers.delete(0);
					got.status     = status_t'(m_axis_tdata[1:0]);
					got.head_id    = m_axis_tdata[17:2];
					got.head_level = m_axis_tdata[20:18];
					got.present    = m_axis_tdata[21];
					got.occupancy  = m_axis_tdata[26:22];
					check_field("status", want.status, got.status);
					check_field("head_id", want.head_id, got.head_id);
					check_field("head_level", want.head_level, got.head_level);
					check_field("present", want.present, got.present);
					check_field("occupancy", want.occupancy, got.occupancy);
					answer_count++;
					if (want.status == ST_FULL)
						drop_count++;
					if (want.status == ST_EMPTY)
						empty_count++;
					if (want.present)
						hit_count++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				answers.insert(answers.size(), serve_request(req_t'(s_axis_tuser),
					s_axis_tdata[15:0], s_axis_tdata[18:16]));
		end
		errors      <= fail_count;
		answers_due <= answers.size();
		answered    <= answer_count;
		dropped     <= drop_count;
		empty_reads <= empty_count;
		query_hits  <= hit_count;
	end

endmodule

### bench/tb_sorted_priority_wait_queue.sv
`timescale 1ns / 1ps
// Top of the sorted priority wait queue bench: clock, reset, request stimulus, verdict.
// Depends on swq_pkg, sorted_priority_wait_queue and swq_checker.
module tb_sorted_priority_wait_queue;
	import swq_pkg::*;

	localparam int ITEMS       = 1000;
	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// requester_id[15:0], priority_level[18:16], zero fill
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// req_type[1:0]
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// status[1:0], head_id[17:2], head_level[20:18], present[21], occupancy[26:22], zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int errors;
	int answers_due;
	int answered;
	int dropped;
	int empty_reads;
	int query_hits;
	int cycles = 0;

	int          rx_tick = 0;
	int          rx_mode = 0;
	logic [15:0] rx_mask = 16'hFFFF;

	always #10 clk = ~clk;

	sorted_priority_wait_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	swq_checker i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.answers_due   (answers_due),
		.answered      (answered),
		.dropped       (dropped),
		.empty_reads   (empty_reads),
		.query_hits    (query_hits)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, answers_due);
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: switch now and then between always ready, random stalls and a stall mask
	always @(posedge clk) begin
		if (rx_tick % 150 == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mask = 16'($urandom) | 16'h0001;
		end
		case (rx_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= rx_mask[rx_tick % 16];
		endcase
		rx_tick++;
	end

	task automatic send_item(req_t req, logic [ID_W-1:0] id, logic [LVL_W-1:0] level);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, level, id};
		s_axis_tuser  <= req;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every result is back; the count is registered, so step first
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (answers_due != 0);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int   sent;
		int   burst_left;
		int   enq_pct;
		int   roll;
		req_t req;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] level;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, no-op request, fill to full with extreme fields
		send_item(REQ_DEQUEUE, 16'($urandom), 3'($urandom));
		send_item(REQ_QUERY, 16'h0000, 3'd0);
		send_item(REQ_NONE, 16'hFFFF, 3'd7);
		send_item(REQ_ENQUEUE, 16'h0000, 3'd0);
		send_item(REQ_ENQUEUE, 16'hFFFF, 3'd7);
		for (int i = 2; i < 16; i++)
			send_item(REQ_ENQUEUE, 16'h0100 + 16'(i), 3'((i * 3) % 8));
		send_item(REQ_ENQUEUE, 16'hABCD, 3'd2);
		send_item(REQ_QUERY, 16'hFFFF, 3'd5);
		send_item(REQ_QUERY, 16'hABCD, 3'd0);
		repeat (3) send_item(REQ_DEQUEUE, 16'h5A5A, 3'd0);
		wait_drained();

		// Random: phases lean toward filling or emptying so both ends are hit often
		sent       = 0;
		burst_left = 0;
		enq_pct    = 50;
		while (sent < ITEMS) begin
			if (sent % 125 == 0) begin
				case ($urandom_range(0, 2))
					0:       enq_pct = 80;
					1:       enq_pct = 50;
					default: enq_pct = 20;
				endcase
				if ($urandom_range(0, 1) == 0)
					wait_drained();
			end
			if (burst_left == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
				burst_left = $urandom_range(1, 24);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				req = REQ_NONE;
			else if (roll < 15)
				req = REQ_QUERY;
			else if (roll < 15 + (85 * enq_pct) / 100)
				req = REQ_ENQUEUE;
			else
				req = REQ_DEQUEUE;
			// small id pool so queries find matches and duplicates occur
			id    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
			level = 3'($urandom_range(0, 7));
			send_item(req, id, level);
			burst_left--;
			sent++;
		end
		wait_drained();

		$display("Checked %0d results: %0d enqueues dropped on full, %0d dequeues on empty,",
			answered, dropped, empty_reads);
		$display("%0d queries found their id, with random gaps on both streams", query_hits);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sorted_priority_wait_queue.f
rtl/swq_pkg.sv
rtl/swq_cell.sv
rtl/sorted_priority_wait_queue.sv
bench/swq_checker.sv
bench/tb_sorted_priority_wait_queue.sv
